// ===== rtl/jpvf_pkg.sv =====
// Package for the joint position and velocity filter: types, constants and saturation helper.
`default_nettype none

package jpvf_pkg;

  // Joint bank size and table index width
  localparam int NUM_JOINTS = 16;
  localparam int JOINT_AW   = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_OFFSET = 1'b1;

  // Filter coefficients (unsigned Q0.16) and velocity scale (us per second)
  localparam logic signed [20:0] COEF_OLD  = 21'sd39322;
  localparam logic signed [20:0] COEF_PAIR = 21'sd12976;
  localparam logic signed [20:0] US_SCALE  = 21'sd1000000;
  localparam logic signed [53:0] ROUND_HALF = 54'sd32768;

  // Offset write window: strictly inside +/- 0.5 rad in Q11.20
  localparam logic signed [31:0] HALF_RAD = 32'sd524288;

  // Saturation limits
  localparam logic signed [53:0] SAT_HI = 54'sd2147483647;
  localparam logic signed [53:0] SAT_LO = -54'sd2147483648;
  localparam logic signed [31:0] Q_MAX  = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN  = 32'sh80000000;

  // Result status codes
  typedef enum logic [1:0] {
    ST_SAMPLE  = 2'd0,
    ST_OFS_OK  = 2'd1,
    ST_OFS_REJ = 2'd2
  } status_t;

  // Input transaction
  typedef struct packed {
    logic               func;
    logic [3:0]         joint;
    logic signed [31:0] value;
    logic [19:0]        elapsed_us;
  } jpvf_in_t;

  // Result transaction
  typedef struct packed {
    logic [3:0]         joint_out;
    logic signed [31:0] filtered_position;
    logic signed [31:0] filtered_velocity;
    status_t            status;
  } jpvf_out_t;

  // One joint's stored state
  typedef struct packed {
    logic signed [31:0] offset;
    logic signed [31:0] raw_pos;
    logic signed [31:0] filt_pos;
    logic signed [31:0] raw_vel;
    logic signed [31:0] filt_vel;
  } joint_rec_t;

  // Table write strobes
  typedef struct packed {
    logic trk_we;
    logic off_we;
  } st_wr_t;

  // Sequencer states
  typedef enum logic [4:0] {
    SQ_IDLE,
    SQ_OFS,
    SQ_READ,
    SQ_SUM,
    SQ_PM1,
    SQ_PM2,
    SQ_PFIN,
    SQ_VMUL,
    SQ_VSTART,
    SQ_VWAIT,
    SQ_SM1,
    SQ_SM2,
    SQ_SFIN,
    SQ_RMUL,
    SQ_RSTART,
    SQ_RWAIT,
    SQ_COMMIT
  } seq_state_t;

  // Divider states
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [53:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = Q_MAX;
    end else if (x < SAT_LO) begin
      r = Q_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/joint_position_velocity_filter.sv =====
// Top level: sequencer around a shared multiplier, an iterative divider and the joint tables.
`default_nettype none

// Conditions position samples for a bank of joints and keeps per-joint offsets.
// One transaction is worked on at a time; in_ready is high only when the sequencer
// is idle. A position sample goes through these steps from its acceptance to the
// next acceptance: reading the tables, adding the offset and running the position
// filter and velocity product on the shared 33x21 multiplier, two passes through
// the radix-2 divider (setup, one quotient bit per cycle for 32 bits, finish; only
// setup and finish when the quotient saturates), the velocity filter and the second
// product, a commit step and the idle state that accepts. An offset write goes
// through the idle state and one write step; a sample dropped for zero elapsed time
// or an out-of-range joint is taken in the idle state alone and gives no result.
// The result waits in an output register, so a new transaction is taken while it is
// still pending; a sequence only stalls at its commit step, or an offset write at its
// write step, if the previous result has not yet been taken.
module joint_position_velocity_filter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire jpvf_pkg::jpvf_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output jpvf_pkg::jpvf_out_t      out_data
);
  import jpvf_pkg::*;

  seq_state_t         state_r, state_nxt;
  jpvf_in_t           it_r;
  jpvf_out_t          out_r;
  logic               out_valid_r;

  joint_rec_t         rd;
  joint_rec_t         wr_rec;
  st_wr_t             st_wr;
  logic [JOINT_AW-1:0] addr;

  logic signed [53:0] p_r;
  logic signed [53:0] acc_r;
  logic signed [31:0] new_raw_r;
  logic signed [31:0] new_f_r;
  logic signed [31:0] vel_f_r;
  logic signed [31:0] new_sv_r;
  logic signed [31:0] raw_vel_r;

  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] rnd_sum;
  logic signed [53:0] rnd_shr;
  logic signed [32:0] raw_sum;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic               out_free;
  logic               out_load;
  logic               in_joint_ok;
  logic               it_joint_ok;
  logic               ofs_ok;

  assign addr        = JOINT_AW'(it_r.joint);
  assign in_joint_ok = ({28'd0, in_data.joint} < 32'(NUM_JOINTS));
  assign it_joint_ok = ({28'd0, it_r.joint} < 32'(NUM_JOINTS));
  assign ofs_ok      = it_joint_ok && (it_r.value > -HALF_RAD) && (it_r.value < HALF_RAD);
  assign out_free    = !out_valid_r || out_ready;

  jpvf_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr    (addr),
    .wr      (st_wr),
    .wr_data (wr_rec),
    .rd_data (rd)
  );

  jpvf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (p_r),
    .divisor  (it_r.elapsed_us),
    .done     (div_done),
    .quotient (div_q)
  );

  // Write-back record
  always_comb begin
    wr_rec.offset   = it_r.value;
    wr_rec.raw_pos  = new_raw_r;
    wr_rec.filt_pos = new_f_r;
    wr_rec.raw_vel  = raw_vel_r;
    wr_rec.filt_vel = new_sv_r;
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, handshake and unit control
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    st_wr     = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      SQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.func == FUNC_OFFSET) begin
            state_nxt = SQ_OFS;
          end else if (in_joint_ok && (in_data.elapsed_us != 20'd0)) begin
            state_nxt = SQ_READ;
          end
        end
      end
      SQ_OFS: begin
        if (out_free) begin
          out_load     = 1'b1;
          st_wr.off_we = ofs_ok;
          state_nxt    = SQ_IDLE;
        end
      end
      SQ_READ:  state_nxt = SQ_SUM;
      SQ_SUM:   state_nxt = SQ_PM1;
      SQ_PM1: begin
        mul_a     = {rd.filt_pos[31], rd.filt_pos};
        mul_b     = COEF_OLD;
        state_nxt = SQ_PM2;
      end
      SQ_PM2: begin
        mul_a     = $signed({rd.raw_pos[31], rd.raw_pos}) + $signed({new_raw_r[31], new_raw_r});
        mul_b     = COEF_PAIR;
        state_nxt = SQ_PFIN;
      end
      SQ_PFIN:  state_nxt = SQ_VMUL;
      SQ_VMUL: begin
        mul_a     = $signed({new_f_r[31], new_f_r}) - $signed({rd.filt_pos[31], rd.filt_pos});
        mul_b     = US_SCALE;
        state_nxt = SQ_VSTART;
      end
      SQ_VSTART: begin
        div_start = 1'b1;
        state_nxt = SQ_VWAIT;
      end
      SQ_VWAIT: if (div_done) state_nxt = SQ_SM1;
      SQ_SM1: begin
        mul_a     = {rd.filt_vel[31], rd.filt_vel};
        mul_b     = COEF_OLD;
        state_nxt = SQ_SM2;
      end
      SQ_SM2: begin
        mul_a     = $signed({rd.raw_vel[31], rd.raw_vel}) + $signed({vel_f_r[31], vel_f_r});
        mul_b     = COEF_PAIR;
        state_nxt = SQ_SFIN;
      end
      SQ_SFIN:  state_nxt = SQ_RMUL;
      SQ_RMUL: begin
        mul_a     = $signed({new_raw_r[31], new_raw_r}) - $signed({rd.raw_pos[31], rd.raw_pos});
        mul_b     = US_SCALE;
        state_nxt = SQ_RSTART;
      end
      SQ_RSTART: begin
        div_start = 1'b1;
        state_nxt = SQ_RWAIT;
      end
      // Last quotient lands in raw_vel_r on leaving this state
      SQ_RWAIT: if (div_done) state_nxt = SQ_COMMIT;
      SQ_COMMIT: begin
        // Commit once the output slot is free
        if (out_free) begin
          out_load     = 1'b1;
          st_wr.trk_we = 1'b1;
          state_nxt    = SQ_IDLE;
        end
      end
      default:  state_nxt = SQ_IDLE;
    endcase
  end

  // Shared arithmetic: offset add and rounding/saturating filter output
  always_comb begin
    raw_sum = $signed({it_r.value[31], it_r.value}) + $signed({rd.offset[31], rd.offset});
    rnd_sum = acc_r + p_r + ROUND_HALF;
    rnd_shr = rnd_sum >>> 16;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (in_ready && in_valid) begin
      it_r <= in_data;
    end
    case (state_r)
      SQ_SUM:  new_raw_r <= sat32({{21{raw_sum[32]}}, raw_sum});
      SQ_PM2,
      SQ_SM2:  acc_r <= p_r;
      SQ_PFIN: new_f_r <= sat32(rnd_shr);
      SQ_VWAIT: begin
        if (div_done) vel_f_r <= div_q;
      end
      SQ_SFIN: new_sv_r <= sat32(rnd_shr);
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.joint_out <= it_r.joint;
      if (state_r == SQ_OFS) begin
        out_r.filtered_position <= '0;
        out_r.filtered_velocity <= '0;
        out_r.status            <= ofs_ok ? ST_OFS_OK : ST_OFS_REJ;
      end else begin
        out_r.filtered_position <= new_f_r;
        out_r.filtered_velocity <= new_sv_r;
        out_r.status            <= ST_SAMPLE;
      end
    end
    if (state_r == SQ_RWAIT && div_done) begin
      raw_vel_r <= div_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/jpvf_div.sv =====
// Iterative radix-2 divider: signed 54-bit dividend by unsigned 20-bit divisor, saturated quotient.
`default_nettype none

module jpvf_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [53:0]       dividend,
  input  wire logic [19:0]              divisor,
  output logic                          done,
  output logic signed [31:0]            quotient
);
  import jpvf_pkg::*;

  div_state_t         state_r, state_nxt;
  logic [53:0]        mag_r;
  logic               neg_r;
  logic               sat_r;
  logic [19:0]        dvs_r;
  logic [19:0]        rem_r;
  logic [31:0]        num_r;
  logic [4:0]         cnt_r;

  logic [20:0]        shl;
  logic               qbit;
  logic [20:0]        rem_sub;
  logic signed [32:0] sval;

  // One quotient bit per cycle
  always_comb begin
    shl     = {rem_r, num_r[31]};
    qbit    = (shl >= {1'b0, dvs_r});
    rem_sub = qbit ? (shl - {1'b0, dvs_r}) : shl;
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE:  if (start) state_nxt = DV_CHECK;
      DV_CHECK: begin
        if (mag_r >= {2'b00, dvs_r, 32'd0}) begin
          state_nxt = DV_DONE;
        end else begin
          state_nxt = DV_RUN;
        end
      end
      DV_RUN:   if (cnt_r == 5'd31) state_nxt = DV_DONE;
      DV_DONE:  state_nxt = DV_IDLE;
      default:  state_nxt = DV_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          neg_r <= dividend[53];
          mag_r <= dividend[53] ? 54'(-dividend) : 54'(dividend);
          dvs_r <= divisor;
        end
      end
      DV_CHECK: begin
        // Quotient of 2^32 or more always clamps; otherwise the high part is below the divisor
        sat_r <= (mag_r >= {2'b00, dvs_r, 32'd0});
        rem_r <= mag_r[51:32];
        num_r <= mag_r[31:0];
        cnt_r <= 5'd0;
      end
      DV_RUN: begin
        rem_r <= rem_sub[19:0];
        num_r <= {num_r[30:0], qbit};
        cnt_r <= cnt_r + 5'd1;
      end
      default: begin
      end
    endcase
  end

  // Signed, saturated result
  always_comb begin
    sval = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
    if (sat_r) begin
      quotient = neg_r ? Q_MIN : Q_MAX;
    end else begin
      quotient = sat32({{21{sval[32]}}, sval});
    end
    done = (state_r == DV_DONE);
  end

endmodule

`default_nettype wire

// ===== rtl/jpvf_store.sv =====
// Per-joint state tables with valid bits standing in for the reset clear.
`default_nettype none

module jpvf_store (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [jpvf_pkg::JOINT_AW-1:0] addr,
  input  wire jpvf_pkg::st_wr_t              wr,
  input  wire jpvf_pkg::joint_rec_t          wr_data,
  output jpvf_pkg::joint_rec_t               rd_data
);
  import jpvf_pkg::*;

  logic [31:0] off_mem [NUM_JOINTS];
  logic [31:0] rpos_mem [NUM_JOINTS];
  logic [31:0] fpos_mem [NUM_JOINTS];
  logic [31:0] rvel_mem [NUM_JOINTS];
  logic [31:0] fvel_mem [NUM_JOINTS];

  logic [NUM_JOINTS-1:0] off_vld_r;
  logic [NUM_JOINTS-1:0] trk_vld_r;
  joint_rec_t            rd_r;

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_vld_r <= '0;
      trk_vld_r <= '0;
    end else begin
      if (wr.off_we) off_vld_r[addr] <= 1'b1;
      if (wr.trk_we) trk_vld_r[addr] <= 1'b1;
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (wr.off_we) begin
      off_mem[addr] <= wr_data.offset;
    end
    if (wr.trk_we) begin
      rpos_mem[addr] <= wr_data.raw_pos;
      fpos_mem[addr] <= wr_data.filt_pos;
      rvel_mem[addr] <= wr_data.raw_vel;
      fvel_mem[addr] <= wr_data.filt_vel;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_r.offset   <= off_vld_r[addr] ? off_mem[addr]  : '0;
    rd_r.raw_pos  <= trk_vld_r[addr] ? rpos_mem[addr] : '0;
    rd_r.filt_pos <= trk_vld_r[addr] ? fpos_mem[addr] : '0;
    rd_r.raw_vel  <= trk_vld_r[addr] ? rvel_mem[addr] : '0;
    rd_r.filt_vel <= trk_vld_r[addr] ? fvel_mem[addr] : '0;
  end

  assign rd_data = rd_r;

endmodule

`default_nettype wire
